// ===== src/quadratic_probe_hash_table_unit_assert.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the quadratic probe hash table unit
// Clocked on clock and disabled during reset; each use states one property.
// ----------------------------------------------------------------------------
`ifndef QUADRATIC_PROBE_HASH_TABLE_UNIT_ASSERT_SVH
`define QUADRATIC_PROBE_HASH_TABLE_UNIT_ASSERT_SVH

// Same-cycle implication.
`define QPHT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define QPHT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== src/qpht_pkg.sv =====
// ----------------------------------------------------------------------------
// qpht_pkg
// Shared types and constants of the quadratic probe hash table unit.
// ----------------------------------------------------------------------------
package qpht_pkg;

   localparam int TABLE_SIZE_DEFAULT = 16;
   localparam int KEY_W              = 31;
   localparam int SLOT_IDX_W         = 4;

   typedef enum logic [1:0] {
      OP_INSERT = 2'd0,
      OP_SEARCH = 2'd1,
      OP_DELETE = 2'd2
   } op_type;

   typedef enum logic [2:0] {
      RES_INSERTED  = 3'd0,
      RES_PRESENT   = 3'd1,
      RES_FOUND     = 3'd2,
      RES_NOT_FOUND = 3'd3,
      RES_FULL      = 3'd4
   } status_type;

   typedef enum logic [1:0] {
      SLOT_EMPTY = 2'd0,
      SLOT_USED  = 2'd1,
      SLOT_TOMB  = 2'd2
   } slot_state_type;

   typedef struct packed {
      slot_state_type   state;
      logic [KEY_W-1:0] key;
   } slot_entry_type;

   // Probe generator control
   typedef struct packed {
      logic start;   // load home, restart at probe zero
      logic step;    // advance to next probe
   } pg_ctrl_type;

endpackage

// ===== src/qpht_slot_ram.sv =====
// ----------------------------------------------------------------------------
// qpht_slot_ram
// Slot store: one write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module qpht_slot_ram #(
   parameter int TABLE_SIZE = qpht_pkg::TABLE_SIZE_DEFAULT
) (
   input  logic                            clock,
   input  logic                            wr_en,
   input  logic [$clog2(TABLE_SIZE)-1:0]   wr_addr,
   input  qpht_pkg::slot_entry_type        wr_data,
   input  logic                            rd_en,
   input  logic [$clog2(TABLE_SIZE)-1:0]   rd_addr,
   output qpht_pkg::slot_entry_type        rd_data
);

   qpht_pkg::slot_entry_type ram_ff [TABLE_SIZE];
   qpht_pkg::slot_entry_type rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         ram_ff[wr_addr] <= wr_data;
      end
   end

   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data_ff <= ram_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== src/qpht_home_mod.sv =====
// ----------------------------------------------------------------------------
// qpht_home_mod
// Home slot: key mod table size. Mask for a power of two, else a reciprocal
// multiply and one compare-subtract, each registered.
// ----------------------------------------------------------------------------
module qpht_home_mod #(
   parameter int TABLE_SIZE = qpht_pkg::TABLE_SIZE_DEFAULT
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [qpht_pkg::KEY_W-1:0]         key,
   output logic                               done,
   output logic [$clog2(TABLE_SIZE)-1:0]      home
);

   localparam int IDX_W   = $clog2(TABLE_SIZE);
   localparam int KEY_W   = qpht_pkg::KEY_W;
   localparam int PROD_W  = 2 * KEY_W;
   localparam bit IS_POW2 = (TABLE_SIZE & (TABLE_SIZE - 1)) == 0;
   localparam logic [IDX_W:0]   SIZE_X = (IDX_W + 1)'(TABLE_SIZE);
   // floor(2^31 / size): quotient estimate is low by at most one
   localparam logic [KEY_W-1:0] RECIP  = KEY_W'(64'h8000_0000 / 64'(TABLE_SIZE));

   logic                        mul_ff,   mul_in;
   logic                        done_ff,  done_in;
   logic [PROD_W-1:0]           prod_ff,  prod_in;
   logic [IDX_W:0]              low_ff,   low_in;
   logic [IDX_W-1:0]            rem_ff,   rem_in;
   logic [IDX_W:0]              q_low;
   logic [IDX_W:0]              diff;
   logic [IDX_W:0]              reduced;

   always_comb begin
      q_low   = prod_ff[KEY_W +: IDX_W + 1];
      // key - q*size lies in [0, 2*size), so the low bits are enough
      diff    = low_ff - q_low * SIZE_X;
      reduced = diff - SIZE_X;
      mul_in  = 1'b0;
      done_in = 1'b0;
      prod_in = prod_ff;
      low_in  = low_ff;
      rem_in  = rem_ff;
      if (start) begin
         if (IS_POW2) begin
            rem_in  = key[IDX_W-1:0];
            done_in = 1'b1;
         end else begin
            mul_in  = 1'b1;
            prod_in = PROD_W'(key) * PROD_W'(RECIP);
            low_in  = key[IDX_W:0];
         end
      end else if (mul_ff) begin
         rem_in  = (diff >= SIZE_X) ? reduced[IDX_W-1:0] : diff[IDX_W-1:0];
         done_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_ff  <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         mul_ff  <= mul_in;
         done_ff <= done_in;
      end
      prod_ff <= prod_in;
      low_ff  <= low_in;
      rem_ff  <= rem_in;
   end

   assign done = done_ff;
   assign home = rem_ff;

endmodule

// ===== src/qpht_probe_gen.sv =====
// ----------------------------------------------------------------------------
// qpht_probe_gen
// Quadratic probe addresses: slot = (home + t*t) mod size, t*t kept by
// adding successive odd numbers, each sum reduced by one compare-subtract.
// ----------------------------------------------------------------------------
module qpht_probe_gen #(
   parameter int TABLE_SIZE = qpht_pkg::TABLE_SIZE_DEFAULT
) (
   input  logic                            clock,
   input  logic                            reset,
   input  qpht_pkg::pg_ctrl_type           ctrl,
   input  logic [$clog2(TABLE_SIZE)-1:0]   home,
   output logic [$clog2(TABLE_SIZE)-1:0]   loc,
   output logic                            more
);

   localparam int IDX_W = $clog2(TABLE_SIZE);
   localparam int CNT_W = $clog2(TABLE_SIZE + 1);
   localparam logic [IDX_W:0]   SIZE_X   = (IDX_W + 1)'(TABLE_SIZE);
   localparam logic [CNT_W-1:0] SIZE_CNT = CNT_W'(TABLE_SIZE);

   logic [IDX_W-1:0] home_ff, home_in;
   logic [IDX_W-1:0] sq_ff,   sq_in;    // t*t mod size
   logic [IDX_W-1:0] odd_ff,  odd_in;   // (2t+1) mod size
   logic [CNT_W-1:0] cnt_ff,  cnt_in;   // probes issued
   logic [IDX_W:0]   loc_sum, sq_sum, odd_sum;

   always_comb begin
      loc_sum = {1'b0, home_ff} + {1'b0, sq_ff};
      sq_sum  = {1'b0, sq_ff} + {1'b0, odd_ff};
      odd_sum = {1'b0, odd_ff} + (IDX_W + 1)'(2);
      if (loc_sum >= SIZE_X) loc_sum = loc_sum - SIZE_X;
      if (sq_sum  >= SIZE_X) sq_sum  = sq_sum  - SIZE_X;
      if (odd_sum >= SIZE_X) odd_sum = odd_sum - SIZE_X;
      home_in = home_ff;
      sq_in   = sq_ff;
      odd_in  = odd_ff;
      cnt_in  = cnt_ff;
      if (ctrl.start) begin
         home_in = home;
         sq_in   = '0;
         odd_in  = IDX_W'(1);
         cnt_in  = '0;
      end else if (ctrl.step) begin
         sq_in  = sq_sum[IDX_W-1:0];
         odd_in = odd_sum[IDX_W-1:0];
         cnt_in = cnt_ff + 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= SIZE_CNT;
      end else begin
         cnt_ff <= cnt_in;
      end
      home_ff <= home_in;
      sq_ff   <= sq_in;
      odd_ff  <= odd_in;
   end

   assign loc  = loc_sum[IDX_W-1:0];
   assign more = (cnt_ff != SIZE_CNT);

endmodule

// ===== src/quadratic_probe_hash_table_unit.sv =====
// ----------------------------------------------------------------------------
// quadratic_probe_hash_table_unit
// Open-addressing hash table with quadratic probing and tombstones.
// ----------------------------------------------------------------------------
// One word in asks to insert, search or delete a key; one word out gives the
// status and the slot. Words are handled one at a time. After reset the unit
// sweeps the slot memory to empty, one slot a cycle, holding req_stall high
// throughout. An item then passes from accept to the next accept through
// these steps, where the walk probes 1 to TABLE_SIZE slots: take the word,
// find the home slot, walk the probes (one memory read a cycle, data the
// cycle after), then write back and load the result once the output register
// is free. When TABLE_SIZE is not a power of two the home slot comes from a
// registered reciprocal multiply and then a registered correcting subtract.
// An unknown op code skips the walk and answers not found. The result sits
// in an output register, so the next word is taken while it waits.
// ----------------------------------------------------------------------------
`include "quadratic_probe_hash_table_unit_assert.svh"

module quadratic_probe_hash_table_unit #(
   parameter int TABLE_SIZE = qpht_pkg::TABLE_SIZE_DEFAULT
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // request channel
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic [1:0]                           req_op,
   input  logic [qpht_pkg::KEY_W-1:0]           req_key,
   // response channel
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [2:0]                           rsp_status,
   output logic [qpht_pkg::SLOT_IDX_W-1:0]      rsp_slot_index
);

   localparam int IDX_W = $clog2(TABLE_SIZE);
   localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(TABLE_SIZE - 1);

   typedef enum logic [2:0] {
      ST_CLEAR,    // post-reset sweep to empty
      ST_IDLE,     // ready for a request word
      ST_HASH,     // waiting on home slot
      ST_PROBE,    // walking the probe path
      ST_FINISH    // write back, load response
   } state_type;

   state_type                     state_ff,     state_in;
   logic [IDX_W-1:0]              clr_idx_ff,   clr_idx_in;
   qpht_pkg::op_type              op_ff,        op_in;
   logic [qpht_pkg::KEY_W-1:0]    key_ff,       key_in;

   // walk outcome
   logic                          rd_pend_ff,   rd_pend_in;
   logic [IDX_W-1:0]              rd_loc_ff,    rd_loc_in;
   logic [IDX_W-1:0]              eval_cnt_ff,  eval_cnt_in;
   logic                          hit_ff,       hit_in;
   logic                          empty_ff,     empty_in;
   logic [IDX_W-1:0]              pos_ff,       pos_in;
   logic                          tomb_ok_ff,   tomb_ok_in;
   logic [IDX_W-1:0]              tomb_ff,      tomb_in;

   // response register
   logic                          rsp_valid_ff, rsp_valid_in;
   qpht_pkg::status_type          rsp_status_ff, rsp_status_in;
   logic [qpht_pkg::SLOT_IDX_W-1:0] rsp_slot_ff, rsp_slot_in;

   // unit connections
   logic                          home_start;
   logic                          home_done;
   logic [IDX_W-1:0]              home;
   qpht_pkg::pg_ctrl_type         pg_ctrl;
   logic [IDX_W-1:0]              pg_loc;
   logic                          pg_more;
   logic                          rd_en;
   logic                          wr_en;
   logic [IDX_W-1:0]              wr_addr;
   qpht_pkg::slot_entry_type      wr_data;
   qpht_pkg::slot_entry_type      rd_data;

   logic                          is_empty, is_match, is_tomb;
   logic                          rsp_free;
   logic                          ins_ok;

   qpht_home_mod #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_home (
      .clock (clock),
      .reset (reset),
      .start (home_start),
      .key   (key_in),
      .done  (home_done),
      .home  (home)
   );

   qpht_probe_gen #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_probe (
      .clock (clock),
      .reset (reset),
      .ctrl  (pg_ctrl),
      .home  (home),
      .loc   (pg_loc),
      .more  (pg_more)
   );

   qpht_slot_ram #(
      .TABLE_SIZE (TABLE_SIZE)
   ) u_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (pg_loc),
      .rd_data (rd_data)
   );

   // slot classification of the word just read
   assign is_empty = (rd_data.state == qpht_pkg::SLOT_EMPTY);
   assign is_match = (rd_data.state == qpht_pkg::SLOT_USED) && (rd_data.key == key_ff);
   assign is_tomb  = (rd_data.state == qpht_pkg::SLOT_TOMB);

   // response register free to load this cycle
   assign rsp_free = !rsp_valid_ff || !rsp_stall;
   // insert has somewhere to go: first tombstone, else the empty slot
   assign ins_ok   = tomb_ok_ff || empty_ff;

   always_comb begin
      state_in      = state_ff;
      clr_idx_in    = clr_idx_ff;
      op_in         = op_ff;
      key_in        = key_ff;
      rd_pend_in    = 1'b0;
      rd_loc_in     = rd_loc_ff;
      eval_cnt_in   = eval_cnt_ff;
      hit_in        = hit_ff;
      empty_in      = empty_ff;
      pos_in        = pos_ff;
      tomb_ok_in    = tomb_ok_ff;
      tomb_in       = tomb_ff;
      rsp_valid_in  = rsp_valid_ff;
      rsp_status_in = rsp_status_ff;
      rsp_slot_in   = rsp_slot_ff;
      home_start    = 1'b0;
      pg_ctrl       = '0;
      rd_en         = 1'b0;
      wr_en         = 1'b0;
      wr_addr       = clr_idx_ff;
      wr_data.state = qpht_pkg::SLOT_EMPTY;
      wr_data.key   = '0;

      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_CLEAR: begin
            wr_en = 1'b1;
            if (clr_idx_ff == LAST_IDX) begin
               state_in = ST_IDLE;
            end else begin
               clr_idx_in = clr_idx_ff + 1'b1;
            end
         end

         ST_IDLE: begin
            if (req_valid) begin
               op_in      = qpht_pkg::op_type'(req_op);
               key_in     = req_key;
               hit_in     = 1'b0;
               empty_in   = 1'b0;
               pos_in     = '0;
               tomb_ok_in = 1'b0;
               tomb_in    = '0;
               if (req_op == qpht_pkg::OP_INSERT || req_op == qpht_pkg::OP_SEARCH ||
                   req_op == qpht_pkg::OP_DELETE) begin
                  home_start = 1'b1;
                  state_in   = ST_HASH;
               end else begin
                  state_in = ST_FINISH;
               end
            end
         end

         ST_HASH: begin
            if (home_done) begin
               pg_ctrl.start = 1'b1;
               eval_cnt_in   = '0;
               state_in      = ST_PROBE;
            end
         end

         ST_PROBE: begin
            // issue the next probe read; a read in flight at stop is dropped
            if (pg_more) begin
               rd_en        = 1'b1;
               pg_ctrl.step = 1'b1;
               rd_pend_in   = 1'b1;
               rd_loc_in    = pg_loc;
            end
            // evaluate the slot read last cycle
            if (rd_pend_ff) begin
               eval_cnt_in = eval_cnt_ff + 1'b1;
               if (is_tomb && !tomb_ok_ff) begin
                  tomb_ok_in = 1'b1;
                  tomb_in    = rd_loc_ff;
               end
               priority if (is_empty) begin
                  empty_in = 1'b1;
                  pos_in   = rd_loc_ff;
                  state_in = ST_FINISH;
               end else if (is_match) begin
                  hit_in   = 1'b1;
                  pos_in   = rd_loc_ff;
                  state_in = ST_FINISH;
               end else if (eval_cnt_ff == LAST_IDX) begin
                  state_in = ST_FINISH;
               end else begin
                  // keep walking
               end
            end
         end

         ST_FINISH: begin
            if (rsp_free) begin
               rsp_valid_in  = 1'b1;
               rsp_status_in = qpht_pkg::RES_NOT_FOUND;
               rsp_slot_in   = '0;
               wr_data.key   = key_ff;
               priority if (op_ff == qpht_pkg::OP_INSERT) begin
                  priority if (hit_ff) begin
                     rsp_status_in = qpht_pkg::RES_PRESENT;
                     rsp_slot_in   = qpht_pkg::SLOT_IDX_W'(pos_ff);
                  end else if (ins_ok) begin
                     wr_en         = 1'b1;
                     wr_addr       = tomb_ok_ff ? tomb_ff : pos_ff;
                     wr_data.state = qpht_pkg::SLOT_USED;
                     rsp_status_in = qpht_pkg::RES_INSERTED;
                     rsp_slot_in   = qpht_pkg::SLOT_IDX_W'(wr_addr);
                  end else begin
                     rsp_status_in = qpht_pkg::RES_FULL;
                  end
               end else if ((op_ff == qpht_pkg::OP_SEARCH || op_ff == qpht_pkg::OP_DELETE)
                            && hit_ff) begin
                  rsp_status_in = qpht_pkg::RES_FOUND;
                  rsp_slot_in   = qpht_pkg::SLOT_IDX_W'(pos_ff);
                  if (op_ff == qpht_pkg::OP_DELETE) begin
                     wr_en         = 1'b1;
                     wr_addr       = pos_ff;
                     wr_data.state = qpht_pkg::SLOT_TOMB;
                  end
               end else begin
                  // miss or unknown op: not found, table unchanged
               end
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_CLEAR;
         clr_idx_ff   <= '0;
         rd_pend_ff   <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         clr_idx_ff   <= clr_idx_in;
         rd_pend_ff   <= rd_pend_in;
         rsp_valid_ff <= rsp_valid_in;
      end
      op_ff         <= op_in;
      key_ff        <= key_in;
      rd_loc_ff     <= rd_loc_in;
      eval_cnt_ff   <= eval_cnt_in;
      hit_ff        <= hit_in;
      empty_ff      <= empty_in;
      pos_ff        <= pos_in;
      tomb_ok_ff    <= tomb_ok_in;
      tomb_ff       <= tomb_in;
      rsp_status_ff <= rsp_status_in;
      rsp_slot_ff   <= rsp_slot_in;
   end

   assign req_stall      = (state_ff != ST_IDLE);
   assign rsp_valid      = rsp_valid_ff;
   assign rsp_status     = rsp_status_ff;
   assign rsp_slot_index = rsp_slot_ff;

   // memory written only by the sweep or at write-back
   `QPHT_ASSERT_NOW(a_wr_when, wr_en, (state_ff == ST_CLEAR || state_ff == ST_FINISH), "slot write outside sweep or write-back")
   // once every probe is issued, the last read must be pending so the walk ends
   `QPHT_ASSERT_NOW(a_walk_ends, (state_ff == ST_PROBE && !pg_more), rd_pend_ff, "probe path exhausted with no read pending")
   // no request word taken during the clearing sweep
   `QPHT_ASSERT_NOW(a_clear_stall, (state_ff == ST_CLEAR), req_stall, "request open during sweep")
   // a write-back always closes the item
   `QPHT_ASSERT_NEXT(a_wb_done, (state_ff == ST_FINISH && wr_en), (state_ff == ST_IDLE && rsp_valid_ff), "write-back without response")

endmodule

// ===== bench/tb_top.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the quadratic probe hash table unit.
// ----------------------------------------------------------------------------
// A short table of directed words is followed by random traffic over a small
// key pool, with random idling on both channels. A mirror of the slot table
// predicts each response at the moment its request word is taken.
// ----------------------------------------------------------------------------
module tb_top;

   localparam int          TBL_SIZE   = qpht_pkg::TABLE_SIZE_DEFAULT;
   localparam int          LONG_HOLD  = 200;   // cycles of forced response back-pressure
   localparam int          POOL_DEPTH = 12;
   localparam logic [1:0]  OP_UNUSED  = 2'd3;  // op code outside the enum: answers not found

   typedef struct packed {
      qpht_pkg::status_type              status;
      logic [qpht_pkg::SLOT_IDX_W-1:0]   slot;
   } hash_result_type;

   // Directed row: the response is typed in only where it is obvious,
   // otherwise the mirror supplies it.
   typedef struct {
      logic [1:0]                        op;
      logic [qpht_pkg::KEY_W-1:0]        key;
      bit                                typed;
      qpht_pkg::status_type              status;
      logic [qpht_pkg::SLOT_IDX_W-1:0]   slot;
   } probe_row_type;

   logic                              clock          = 1'b0;
   logic                              reset          = 1'b1;
   logic                              req_valid      = 1'b0;
   logic                              req_stall;
   logic [1:0]                        req_op         = qpht_pkg::OP_INSERT;
   logic [qpht_pkg::KEY_W-1:0]        req_key        = '0;
   logic                              rsp_valid;
   logic                              rsp_stall      = 1'b1;
   logic [2:0]                        rsp_status;
   logic [qpht_pkg::SLOT_IDX_W-1:0]   rsp_slot_index;

   // Mirror of the slot table
   qpht_pkg::slot_state_type          mirror_state [TBL_SIZE];
   logic [qpht_pkg::KEY_W-1:0]        mirror_key   [TBL_SIZE];

   hash_result_type                   lookup_results_due [$];
   logic [qpht_pkg::KEY_W-1:0]        key_pool [POOL_DEPTH];
   bit                                pool_ready     = 1'b0;

   int                      fail_count     = 0;
   int                      send_idle_pct  = 0;
   int                      recv_idle_pct  = 0;
   int                      hold_asked     = 0;   // written by stimulus only
   int                      hold_served    = 0;   // written by stall generator only
   int                      hold_left      = 0;

   // Home 5 collides on slots 5, 6, 9 and 14 only, so four keys fill the path.
   probe_row_type probe_table [22] = '{
      '{qpht_pkg::OP_SEARCH, 31'h0000_0000, 1'b1, qpht_pkg::RES_NOT_FOUND, 4'd0}, // empty
      '{OP_UNUSED, 31'h7FFF_FFFF, 1'b1, qpht_pkg::RES_NOT_FOUND, 4'd0},   // unknown op
      '{qpht_pkg::OP_INSERT, 31'h0000_0000, 1'b1, qpht_pkg::RES_INSERTED, 4'd0},  // lowest
      '{qpht_pkg::OP_INSERT, 31'h7FFF_FFFF, 1'b1, qpht_pkg::RES_INSERTED, 4'd15}, // highest
      '{qpht_pkg::OP_INSERT, 31'h0000_0000, 1'b0, qpht_pkg::RES_NOT_FOUND, 4'd0}, // present
      '{qpht_pkg::OP_SEARCH, 31'h7FFF_FFFF, 1'b0, qpht_pkg::RES_NOT_FOUND, 4'd0},
      '{qpht_pkg::OP_INSERT, 31'd5,         1'b0, qpht_pkg::RES_NOT_FOUND, 4'd0},
      '{qpht_pkg::OP_INSERT, 31'd21,        1'b0, qpht_pkg::RES_NOT_FOUND, 4'd0},
      '{qpht_pkg::OP_INSERT, 31'd37,        1'b0, qpht_pkg::RES_NOT_FOUND, 4'd0},
      '{qpht_pkg::OP_INSERT, 31'd53,        1'b0, qpht_pkg::RES_NOT_FOUND, 4'd0},
      // path full, no tombstone
      '{qpht_pkg::OP_INSERT, 31'd69,        1'b1, qpht_pkg::RES_FULL,      4'd0},
      // leaves a tombstone
      '{qpht_pkg::OP_DELETE, 31'd21,        1'b0, qpht_pkg::RES_NOT_FOUND, 4'd0},
      // gone, no empty slot
      '{qpht_pkg::OP_DELETE, 31'd21,        1'b1, qpht_pkg::RES_NOT_FOUND, 4'd0},
      // walks over tombstone
      '{qpht_pkg::OP_SEARCH, 31'd37,        1'b0, qpht_pkg::RES_NOT_FOUND, 4'd0},
      // reuses tombstone
      '{qpht_pkg::OP_INSERT, 31'd69,        1'b0, qpht_pkg::RES_NOT_FOUND, 4'd0},
      // empty home slot
      '{qpht_pkg::OP_DELETE, 31'd99,        1'b1, qpht_pkg::RES_NOT_FOUND, 4'd0},
      // unknown op, key present
      '{OP_UNUSED,           31'd5,         1'b1, qpht_pkg::RES_NOT_FOUND, 4'd0},
      '{qpht_pkg::OP_DELETE, 31'h7FFF_FFFF, 1'b0, qpht_pkg::RES_NOT_FOUND, 4'd0},
      // home match, key differs
      '{qpht_pkg::OP_SEARCH, 31'h4000_0000, 1'b0, qpht_pkg::RES_NOT_FOUND, 4'd0},
      '{qpht_pkg::OP_INSERT, 31'h2AAA_AAAA, 1'b0, qpht_pkg::RES_NOT_FOUND, 4'd0},
      '{qpht_pkg::OP_SEARCH, 31'h5555_5555, 1'b0, qpht_pkg::RES_NOT_FOUND, 4'd0},
      // tombstone at home slot
      '{qpht_pkg::OP_INSERT, 31'h7FFF_FFFF, 1'b0, qpht_pkg::RES_NOT_FOUND, 4'd0}
   };

   quadratic_probe_hash_table_unit #(
      .TABLE_SIZE     (TBL_SIZE)
   ) i_dut (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_op         (req_op),
      .req_key        (req_key),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_status     (rsp_status),
      .rsp_slot_index (rsp_slot_index)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      repeat (8) @(posedge clock);
      reset <= 1'b0;
   end

   // Walk the probe path of one word over the mirror, update it and return
   // the response. Probing stops at an empty slot, a matching key, or after
   // TBL_SIZE probes; the first tombstone seen is kept for an insert.
   function automatic hash_result_type hash_table_predict(
      input logic [1:0]                 op,
      input logic [qpht_pkg::KEY_W-1:0] key);
      hash_result_type res;
      int              home;
      int              loc;
      int              pos;
      int              tomb;
      int              t;
      bit              hit;
      bit              empty_seen;
      bit              tomb_seen;
      bit              done;
      home       = int'(key % TBL_SIZE);
      pos        = 0;
      tomb       = 0;
      hit        = 1'b0;
      empty_seen = 1'b0;
      tomb_seen  = 1'b0;
      done       = 1'b0;
      for (t = 0; t < TBL_SIZE && !done; t++) begin
         loc = (home + (t * t) % TBL_SIZE) % TBL_SIZE;
         if (mirror_state[loc] == qpht_pkg::SLOT_EMPTY) begin
            empty_seen = 1'b1;
            pos        = loc;
            done       = 1'b1;
         end else if (mirror_state[loc] == qpht_pkg::SLOT_USED && mirror_key[loc] == key) begin
            hit  = 1'b1;
            pos  = loc;
            done = 1'b1;
         end else if (mirror_state[loc] == qpht_pkg::SLOT_TOMB && !tomb_seen) begin
            tomb_seen = 1'b1;
            tomb      = loc;
         end
      end
      res.status = qpht_pkg::RES_NOT_FOUND;
      res.slot   = '0;
      case (op)
         qpht_pkg::OP_INSERT: begin
            if (hit) begin
               res.status = qpht_pkg::RES_PRESENT;
               res.slot   = qpht_pkg::SLOT_IDX_W'(pos);
            end else if (tomb_seen || empty_seen) begin
               if (tomb_seen)
                  pos = tomb;
               mirror_state[pos] = qpht_pkg::SLOT_USED;
               mirror_key[pos]   = key;
               res.status = qpht_pkg::RES_INSERTED;
               res.slot   = qpht_pkg::SLOT_IDX_W'(pos);
            end else begin
               res.status = qpht_pkg::RES_FULL;
            end
         end
         qpht_pkg::OP_SEARCH: begin
            if (hit) begin
               res.status = qpht_pkg::RES_FOUND;
               res.slot   = qpht_pkg::SLOT_IDX_W'(pos);
            end
         end
         qpht_pkg::OP_DELETE: begin
            if (hit) begin
               mirror_state[pos] = qpht_pkg::SLOT_TOMB;
               res.status = qpht_pkg::RES_FOUND;
               res.slot   = qpht_pkg::SLOT_IDX_W'(pos);
            end
         end
         default: ;
      endcase
      return res;
   endfunction

   // Offer one request word and hold it until taken. valid is left high on
   // return so that a following word goes out back to back; the idle loop or
   // the caller lowers it.
   task automatic send_word(input logic [1:0]                 op,
                            input logic [qpht_pkg::KEY_W-1:0] key,
                            input bit                         typed,
                            input hash_result_type            typed_res);
      hash_result_type res;
      while ($urandom_range(99) < send_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_op    <= op;
      req_key   <= key;
      do
         @(posedge clock);
      while (req_stall !== 1'b0);
      // taken at this edge: the mirror moves in acceptance order
      res = hash_table_predict(op, key);
      if (typed)
         res = typed_res;
      lookup_results_due.push_back(res);
   endtask

   // Random traffic. Most keys come from a small pool clustered on one home
   // slot, so that collisions, full paths and tombstone reuse come up often;
   // half the pool is redrawn every hundred words.
   task automatic random_run(input int n_words, input int del_pct);
      int                         i;
      int                         j;
      int                         r;
      logic [31:0]                rnd;
      logic [3:0]                 home;
      logic [3:0]                 home_base;
      logic [1:0]                 op;
      logic [qpht_pkg::KEY_W-1:0] key;
      for (i = 0; i < n_words; i++) begin
         if (i % 100 == 0) begin
            home_base = 4'($urandom_range(TBL_SIZE - 1));
            for (j = 0; j < POOL_DEPTH; j++) begin
               if (!pool_ready || ((j + i / 100) % 2 == 0)) begin
                  rnd  = $urandom;
                  home = (j < 8) ? home_base : 4'($urandom_range(TBL_SIZE - 1));
                  key_pool[j] = {rnd[30:4], home};
               end
            end
            pool_ready = 1'b1;
         end
         r = $urandom_range(99);
         if (r < 5)
            op = OP_UNUSED;
         else if (r < 5 + del_pct)
            op = qpht_pkg::OP_DELETE;
         else if (r < 30 + del_pct)
            op = qpht_pkg::OP_SEARCH;
         else
            op = qpht_pkg::OP_INSERT;
         if ($urandom_range(99) < 80)
            key = key_pool[$urandom_range(POOL_DEPTH - 1)];
         else
            key = qpht_pkg::KEY_W'($urandom);
         send_word(op, key, 1'b0, '0);
      end
   endtask

   // Response back-pressure: random, or a long forced hold when asked for.
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else if (hold_served != hold_asked) begin
         rsp_stall   <= 1'b1;
         hold_served <= hold_asked;
         hold_left   <= LONG_HOLD - 1;
      end else begin
         rsp_stall <= ($urandom_range(99) < recv_idle_pct);
      end
   end

   // Response checker: each taken word is matched against the oldest
   // prediction, field by field.
   always @(posedge clock) begin : rsp_check
      hash_result_type due;
      if (!reset && rsp_valid === 1'b1 && rsp_stall === 1'b0) begin
         if (lookup_results_due.size() == 0) begin
            $error("response word with nothing outstanding: status %0d slot %0d",
                   rsp_status, rsp_slot_index);
            fail_count = fail_count + 1;
         end else begin
            due = lookup_results_due.pop_front();
            if (rsp_status !== due.status) begin
               $error("rsp_status: expected %0d, actual %0d", due.status, rsp_status);
               fail_count = fail_count + 1;
            end
            if (rsp_slot_index !== due.slot) begin
               $error("rsp_slot_index: expected %0d, actual %0d", due.slot, rsp_slot_index);
               fail_count = fail_count + 1;
            end
         end
      end
   end

   initial begin : stimulus
      int              i;
      hash_result_type typed_res;
      for (i = 0; i < TBL_SIZE; i++) begin
         mirror_state[i] = qpht_pkg::SLOT_EMPTY;
         mirror_key[i]   = '0;
      end
      send_idle_pct = 21;
      recv_idle_pct <= 49;
      // the unit sweeps its memory after reset behind req_stall, so the first
      // word simply waits for the handshake
      while (reset)
         @(posedge clock);

      foreach (probe_table[i]) begin
         typed_res.status = probe_table[i].status;
         typed_res.slot   = probe_table[i].slot;
         send_word(probe_table[i].op, probe_table[i].key, probe_table[i].typed, typed_res);
      end
      random_run(530, 15);
      req_valid <= 1'b0;

      // sender pauses until the pipe is empty, then the idling swaps round
      while (lookup_results_due.size() != 0)
         @(posedge clock);
      send_idle_pct = 49;
      recv_idle_pct <= 21;
      random_run(530, 35);
      req_valid <= 1'b0;
      while (lookup_results_due.size() != 0)
         @(posedge clock);

      // no idling; a long response hold fills the output register and the
      // unit has to stall its request side while words keep coming
      send_idle_pct = 0;
      recv_idle_pct <= 0;
      hold_asked    <= hold_asked + 1;
      random_run(540, 25);
      req_valid <= 1'b0;

      while (lookup_results_due.size() != 0)
         @(posedge clock);
      // catch any stray response word
      repeat (2 * TBL_SIZE + 8)
         @(posedge clock);
      if (fail_count == 0)
         $display("tb_top OK");
      else
         $display("tb_top NOT OK");
      $finish;
   end

   initial begin
      #5ms;
      $display("tb_top NOT OK");
      $finish;
   end

endmodule

// ===== files.f =====
+incdir+src
src/qpht_pkg.sv
src/qpht_slot_ram.sv
src/qpht_home_mod.sv
src/qpht_probe_gen.sv
src/quadratic_probe_hash_table_unit.sv
bench/tb_top.sv
